### rtl/core/sfsc_pkg.sv
// shared types and constants of the serial frame sync checker
package sfsc_pkg;

    localparam int BYTE_W          = 8;
    localparam int FRAME_LEN_DEF   = 12;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 16;
    localparam int IDX_W           = 4;
    localparam int CFG_INDEX_W     = 1;
    localparam int CFG_DATA_W      = 8;

    localparam logic [BYTE_W-1:0] HEADER_RST  = 8'hA4;
    localparam logic [BYTE_W-1:0] ADDRESS_RST = 8'h01;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HEADER  = 1'b0,
        CFG_ADDRESS = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

### rtl/core/sfsc_front.sv
// front end: receive window, running checksum and frame match
module sfsc_front #(
    parameter int FRAME_LEN = sfsc_pkg::FRAME_LEN_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        cfg_we,
    input  logic [sfsc_pkg::CFG_INDEX_W-1:0]            cfg_index,
    input  logic [sfsc_pkg::CFG_DATA_W-1:0]             cfg_data,
    input  logic                                        s_tvalid,
    output logic                                        s_tready,
    input  logic [sfsc_pkg::S_TDATA_W-1:0]              s_tdata,
    input  sfsc_pkg::queue_status_t                     q_status,
    output logic                                        push,
    output logic [FRAME_LEN-1:0][sfsc_pkg::BYTE_W-1:0]  push_frame
);

    logic [FRAME_LEN-1:0][sfsc_pkg::BYTE_W-1:0] window_reg, window_next;
    logic [sfsc_pkg::BYTE_W-1:0]                sum_reg, sum_next;
    logic [sfsc_pkg::BYTE_W-1:0]                header_reg, address_reg;
    logic [sfsc_pkg::BYTE_W-1:0]                rx_byte;
    logic                                       accept, match;

    assign rx_byte  = s_tdata[sfsc_pkg::BYTE_W-1:0];
    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        for (int i = 0; i < FRAME_LEN - 1; i++)
        begin
            window_next[i] = window_reg[i+1];
        end
        window_next[FRAME_LEN-1] = rx_byte;
    end

    // sum of all but the newest byte after the shift
    assign sum_next = sum_reg - window_reg[0] + window_reg[FRAME_LEN-1];

    assign match = (window_reg[1] == header_reg) && (window_reg[2] == address_reg)
                   && (sum_next == rx_byte);

    assign push       = accept && match;
    assign push_frame = window_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            sum_reg    <= '0;
        end
        else if (accept)
        begin
            window_reg <= window_next;
            sum_reg    <= sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg  <= sfsc_pkg::HEADER_RST;
            address_reg <= sfsc_pkg::ADDRESS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sfsc_pkg::CFG_HEADER:  header_reg  <= cfg_data[sfsc_pkg::BYTE_W-1:0];
                sfsc_pkg::CFG_ADDRESS: address_reg <= cfg_data[sfsc_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

### rtl/core/sfsc_frame_queue.sv
// small queue of matched frames between detection and emission
module sfsc_frame_queue #(
    parameter int FRAME_LEN   = sfsc_pkg::FRAME_LEN_DEF,
    parameter int QUEUE_DEPTH = sfsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        push,
    input  logic [FRAME_LEN-1:0][sfsc_pkg::BYTE_W-1:0]  push_frame,
    input  logic                                        pop,
    output logic [FRAME_LEN-1:0][sfsc_pkg::BYTE_W-1:0]  rd_frame,
    output sfsc_pkg::queue_status_t                     q_status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [FRAME_LEN-1:0][sfsc_pkg::BYTE_W-1:0] mem [QUEUE_DEPTH];
    logic [FRAME_LEN-1:0][sfsc_pkg::BYTE_W-1:0] head_reg;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign q_status.empty = (count_reg == '0);
    assign rd_frame       = head_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // head of the queue kept in a register, new frame goes straight there when it becomes head
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_frame;
        end
        if (push && (count_reg == '0 || (pop && count_reg == CNT_W'(1))))
        begin
            head_reg <= push_frame;
        end
        else if (pop)
        begin
            head_reg <= mem[rd_ptr_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### rtl/core/sfsc_back.sv
// back end: emits a queued frame one byte per transfer
module sfsc_back #(
    parameter int FRAME_LEN = sfsc_pkg::FRAME_LEN_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  sfsc_pkg::queue_status_t                     q_status,
    input  logic [FRAME_LEN-1:0][sfsc_pkg::BYTE_W-1:0]  rd_frame,
    output logic                                        pop,
    output logic                                        m_tvalid,
    input  logic                                        m_tready,
    output logic [sfsc_pkg::M_TDATA_W-1:0]              m_tdata,
    output logic                                        m_tlast
);

    localparam int POS_W = $clog2(FRAME_LEN);

    logic [FRAME_LEN-1:0][sfsc_pkg::BYTE_W-1:0] frame_reg;
    logic [POS_W-1:0]                           pos_reg;
    logic                                       busy_reg;
    logic                                       xfer, last_pos, done;

    assign last_pos = (pos_reg == POS_W'(FRAME_LEN - 1));
    assign xfer     = busy_reg && m_tready;
    assign done     = xfer && last_pos;
    assign pop      = (!busy_reg || done) && !q_status.empty;

    assign m_tvalid = busy_reg;
    assign m_tlast  = last_pos;
    assign m_tdata  = {{(sfsc_pkg::M_TDATA_W - sfsc_pkg::IDX_W - sfsc_pkg::BYTE_W){1'b0}},
                       sfsc_pkg::IDX_W'(pos_reg), frame_reg[0]};

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            frame_reg <= rd_frame;
        end
        else if (xfer)
        begin
            for (int i = 0; i < FRAME_LEN - 1; i++)
            begin
                frame_reg[i] <= frame_reg[i+1];
            end
            frame_reg[FRAME_LEN-1] <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else if (pop)
        begin
            busy_reg <= 1'b1;
            pos_reg  <= '0;
        end
        else if (done)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= '0;
        end
        else if (xfer)
        begin
            pos_reg <= pos_reg + 1'b1;
        end
    end

endmodule

### rtl/core/serial_frame_sync_checker_unit.sv
// top level of the serial frame sync checker
// One received byte is taken per cycle; the window shift, the running 8-bit sum and the
// header, address and checksum compare all finish in the cycle that takes the byte. A match
// pushes the whole window into a queue of QUEUE_DEPTH frames, and the emitter sends each
// queued frame as FRAME_LEN transfers, one per cycle unless m_tready is low, byte_index
// counting up from zero, tlast on the final byte; the frame is registered as queue head
// before the emitter loads it. The input stalls only while the queue is full; with m_tready
// high it sustains one byte per cycle if matches average at most one per FRAME_LEN bytes.
module serial_frame_sync_checker_unit #(
    parameter int FRAME_LEN   = sfsc_pkg::FRAME_LEN_DEF,
    parameter int QUEUE_DEPTH = sfsc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sfsc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sfsc_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sfsc_pkg::S_TDATA_W-1:0]     s_tdata,   // rx_byte[7:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [sfsc_pkg::M_TDATA_W-1:0]     m_tdata,   // frame_byte[7:0], byte_index[11:8]
    output logic                               m_tlast
);

    sfsc_pkg::queue_status_t                    q_status;
    logic                                       push, pop;
    logic [FRAME_LEN-1:0][sfsc_pkg::BYTE_W-1:0] push_frame, rd_frame;

    sfsc_front #(
        .FRAME_LEN (FRAME_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .q_status   (q_status),
        .push       (push),
        .push_frame (push_frame)
    );

    sfsc_frame_queue #(
        .FRAME_LEN   (FRAME_LEN),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_frame (push_frame),
        .pop        (pop),
        .rd_frame   (rd_frame),
        .q_status   (q_status)
    );

    sfsc_back #(
        .FRAME_LEN (FRAME_LEN)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .rd_frame (rd_frame),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### rtl/core/sfsc_checker.sv
// port-level checks of the output frame sequence, bound to the top level
module sfsc_checker #(
    parameter int FRAME_LEN = sfsc_pkg::FRAME_LEN_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sfsc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    localparam logic [sfsc_pkg::IDX_W-1:0] LAST_IDX = sfsc_pkg::IDX_W'(FRAME_LEN - 1);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tdata[11:8] == LAST_IDX)
        else $error("tlast on wrong byte index");

    a_next_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tdata[11:8] == $past(m_tdata[11:8]) + 4'd1)
        else $error("frame bytes not contiguous");

    a_first_idx: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tdata[11:8] == '0)
        else $error("frame does not start at index zero");

endmodule

bind serial_frame_sync_checker_unit sfsc_checker #(
    .FRAME_LEN (FRAME_LEN)
) u_sfsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

### tb/serial_frame_sync_checker_unit_test.sv
// testbench for the serial frame sync checker: directed rows, random frames, scoreboard
`timescale 1ns / 1ps

module serial_frame_sync_checker_unit_test;

    localparam int FLEN = sfsc_pkg::FRAME_LEN_DEF;

    typedef enum logic [1:0] {
        HIT_PRED,
        HIT_NO,
        HIT_YES
    } hit_t;

    typedef enum logic {
        ROW_BYTE,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t                   kind;
        sfsc_pkg::cfg_reg_t          reg_sel;
        logic [sfsc_pkg::BYTE_W-1:0] value;
        hit_t                        hit;
    } stim_row_t;

    typedef struct packed {
        logic [sfsc_pkg::BYTE_W-1:0] frame_byte;
        logic [sfsc_pkg::IDX_W-1:0]  byte_index;
        logic                        last;
    } frame_byte_t;

    localparam int N_ROWS = 22;
    localparam stim_row_t DIR_ROWS [N_ROWS] = '{
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'h00, HIT_NO},
        '{ROW_CFG,  sfsc_pkg::CFG_HEADER,  8'h00, HIT_PRED},
        '{ROW_CFG,  sfsc_pkg::CFG_ADDRESS, 8'h00, HIT_PRED},
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'h00, HIT_YES},
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'h00, HIT_YES},
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'hFF, HIT_NO},
        '{ROW_CFG,  sfsc_pkg::CFG_HEADER,  8'hFF, HIT_PRED},
        '{ROW_CFG,  sfsc_pkg::CFG_ADDRESS, 8'hFF, HIT_PRED},
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'hFF, HIT_PRED},
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'hFF, HIT_PRED},
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'h01, HIT_PRED},
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'h02, HIT_PRED},
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'h04, HIT_PRED},
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'h08, HIT_PRED},
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'h10, HIT_PRED},
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'h20, HIT_PRED},
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'h40, HIT_PRED},
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'h80, HIT_PRED},
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'h00, HIT_PRED},
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'hFD, HIT_YES},
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'h5A, HIT_PRED},
        '{ROW_BYTE, sfsc_pkg::CFG_HEADER,  8'hA5, HIT_PRED}
    };

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [sfsc_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [sfsc_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [sfsc_pkg::S_TDATA_W-1:0]   s_tdata;    // rx_byte[7:0]
    logic                             m_tvalid;
    logic                             m_tready;
    logic [sfsc_pkg::M_TDATA_W-1:0]   m_tdata;    // frame_byte[7:0], byte_index[11:8]
    logic                             m_tlast;

    logic [sfsc_pkg::BYTE_W-1:0] rx_window [FLEN];
    logic [sfsc_pkg::BYTE_W-1:0] want_header;
    logic [sfsc_pkg::BYTE_W-1:0] want_address;
    frame_byte_t                 frame_bytes_due [$];
    frame_byte_t                 due;

    int src_idle_pct;
    int snk_stall_pct;
    int errors;
    int bytes_sent;
    int frames_hit;
    int bytes_checked;

    serial_frame_sync_checker_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #4 clk = ~clk;

    // shift one byte into the window, report header, address and checksum match
    function automatic logic shift_in(logic [sfsc_pkg::BYTE_W-1:0] b);
        logic [sfsc_pkg::BYTE_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < FLEN - 1; i++)
        begin
            rx_window[i] = rx_window[i+1];
        end
        rx_window[FLEN-1] = b;
        for (int i = 0; i < FLEN - 1; i++)
        begin
            sum = sum + rx_window[i];
        end
        return rx_window[0] == want_header && rx_window[1] == want_address
            && sum == rx_window[FLEN-1];
    endfunction

    function automatic void queue_frame();
        frame_byte_t fb;
        for (int i = 0; i < FLEN; i++)
        begin
            fb.frame_byte = rx_window[i];
            fb.byte_index = i[sfsc_pkg::IDX_W-1:0];
            fb.last       = (i == FLEN - 1);
            frame_bytes_due.push_back(fb);
        end
        frames_hit++;
    endfunction

    task automatic send_byte(input logic [sfsc_pkg::BYTE_W-1:0] b, input hit_t hit);
        logic hit_now;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge clk); while (!s_tready);
        hit_now = shift_in(b);
        if (hit != HIT_PRED)
        begin
            hit_now = (hit == HIT_YES);
        end
        if (hit_now)
        begin
            queue_frame();
        end
        bytes_sent++;
        @(negedge clk);
    endtask

    // drain all expected frame bytes, then give the block time to go quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (frame_bytes_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input sfsc_pkg::cfg_reg_t sel,
                             input logic [sfsc_pkg::BYTE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        if (sel == sfsc_pkg::CFG_HEADER)
        begin
            want_header = v;
        end
        else
        begin
            want_address = v;
        end
    endtask

    task automatic run_phase(input int n_items);
        logic [sfsc_pkg::BYTE_W-1:0] fr [FLEN];
        logic [sfsc_pkg::BYTE_W-1:0] sum;
        int                          sent;
        int                          pick;
        int                          pos;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                fr[0] = want_header;
                fr[1] = want_address;
                sum   = want_header + want_address;
                for (int i = 2; i < FLEN - 1; i++)
                begin
                    fr[i] = 8'($urandom);
                    sum   = sum + fr[i];
                end
                fr[FLEN-1] = sum;
                // broken frame: one byte damaged
                if (pick >= 62)
                begin
                    pos     = $urandom_range(FLEN - 1);
                    fr[pos] = fr[pos] ^ 8'($urandom_range(255, 1));
                end
                for (int i = 0; i < FLEN; i++)
                begin
                    send_byte(fr[i], HIT_PRED);
                end
                sent += FLEN;
            end
            else
            begin
                pos = $urandom_range(5, 1);
                for (int i = 0; i < pos; i++)
                begin
                    send_byte(8'($urandom), HIT_PRED);
                end
                sent += pos;
            end
        end
    endtask

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_bytes_due.size() == 0)
            begin
                $error("unexpected transfer: tdata %h tlast %b", m_tdata, m_tlast);
                errors++;
            end
            else
            begin
                due = frame_bytes_due.pop_front();
                bytes_checked++;
                if (m_tdata[7:0] !== due.frame_byte)
                begin
                    $error("frame_byte: expected %h, got %h", due.frame_byte, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[11:8] !== due.byte_index)
                begin
                    $error("byte_index: expected %0d, got %0d", due.byte_index,
                        m_tdata[11:8]);
                    errors++;
                end
                if (m_tlast !== due.last)
                begin
                    $error("last: expected %b, got %b", due.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = sfsc_pkg::CFG_HEADER;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        errors        = 0;
        bytes_sent    = 0;
        frames_hit    = 0;
        bytes_checked = 0;
        want_header   = sfsc_pkg::HEADER_RST;
        want_address  = sfsc_pkg::ADDRESS_RST;
        for (int i = 0; i < FLEN; i++)
        begin
            rx_window[i] = '0;
        end
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < N_ROWS; r++)
        begin
            if (DIR_ROWS[r].kind == ROW_CFG)
            begin
                settle();
                write_reg(DIR_ROWS[r].reg_sel, DIR_ROWS[r].value);
            end
            else
            begin
                send_byte(DIR_ROWS[r].value, DIR_ROWS[r].hit);
            end
        end

        for (int p = 0; p < 8; p++)
        begin
            settle();
            case (p)
                0:
                begin
                    write_reg(sfsc_pkg::CFG_HEADER, sfsc_pkg::HEADER_RST);
                    write_reg(sfsc_pkg::CFG_ADDRESS, sfsc_pkg::ADDRESS_RST);
                end
                1:
                begin
                    write_reg(sfsc_pkg::CFG_HEADER, 8'h00);
                    write_reg(sfsc_pkg::CFG_ADDRESS, 8'h00);
                end
                2:
                begin
                    write_reg(sfsc_pkg::CFG_HEADER, 8'hFF);
                    write_reg(sfsc_pkg::CFG_ADDRESS, 8'hFF);
                end
                3:
                begin
                    write_reg(sfsc_pkg::CFG_HEADER, 8'hFF);
                    write_reg(sfsc_pkg::CFG_ADDRESS, 8'h00);
                end
                default:
                begin
                    write_reg(sfsc_pkg::CFG_HEADER, 8'($urandom));
                    write_reg(sfsc_pkg::CFG_ADDRESS, 8'($urandom));
                end
            endcase
            case (p % 4)
                0:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 71;
                    snk_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    snk_stall_pct = 71;
                end
                default:
                begin
                    src_idle_pct  = 23;
                    snk_stall_pct = 23;
                end
            endcase
            run_phase(40);
        end

        settle();
        repeat (8) @(negedge clk);
        $display("%0d bytes sent over 8 register settings and 4 idle modes", bytes_sent);
        $display("%0d frames matched, %0d frame bytes checked", frames_hit, bytes_checked);
        if (errors == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/sfsc_pkg.sv
rtl/core/sfsc_front.sv
rtl/core/sfsc_frame_queue.sv
rtl/core/sfsc_back.sv
rtl/core/serial_frame_sync_checker_unit.sv
rtl/core/sfsc_checker.sv
tb/serial_frame_sync_checker_unit_test.sv
